@@ rtl/lbs_pkg.sv @@
// ----------------------------------------------------------------------------
// lbs_pkg: shared types and constants
// Controller states, command and status bundles, and fixed-point limits for
// the four-influence linear blend skinning block.
// ----------------------------------------------------------------------------
package lbs_pkg;

    // Influences that have fields in an input item
    localparam int FIELD_INFLUENCES = 4;
    // Elements of one 4x4 skin matrix
    localparam int MATRIX_ELEMS = 16;
    // Quotient bits produced by the divider, one per step
    localparam int DIV_STEPS = 32;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_VERTEX = 1'b1;

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_INIT,
        ST_CHECK,
        ST_FETCH,
        ST_DRAIN,
        ST_DIVLOAD,
        ST_DIV,
        ST_MUL,
        ST_ADD,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic       capture;
        logic       write;
        logic       init;
        logic       clear_sum;
        logic       rd_en;
        logic [3:0] elem;
        logic [2:0] infl;
        logic       div_load;
        logic       div_step;
        logic       mul;
        logic       add;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic is_vertex;
        logic skip;
        logic busy;
        logic out_free;
    } status_t;

endpackage

@@ rtl/lbs_if.sv @@
// ----------------------------------------------------------------------------
// lbs_if: item channels
// Valid/ready channels for input items and skinned results.
// ----------------------------------------------------------------------------
interface lbs_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [9:0]  load_address;
    logic [31:0] load_value;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [23:0] joint_ids;
    logic [15:0] weight_0;
    logic [15:0] weight_1;
    logic [15:0] weight_2;
    logic [15:0] weight_3;

    modport source (
        output valid, kind, load_address, load_value, pos_x, pos_y, pos_z,
               joint_ids, weight_0, weight_1, weight_2, weight_3,
        input  ready
    );
    modport sink (
        input  valid, kind, load_address, load_value, pos_x, pos_y, pos_z,
               joint_ids, weight_0, weight_1, weight_2, weight_3,
        output ready
    );
endinterface

interface lbs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic        fault;

    modport source (
        output valid, out_x, out_y, out_z, fault,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z, fault,
        output ready
    );
endinterface

@@ rtl/lbs_ctrl.sv @@
// ----------------------------------------------------------------------------
// lbs_ctrl: skinning sequencer
// Writes load items; steps vertices through influences: matrix fetch,
// shared divide, weighting and the final rounding into the output register.
// ----------------------------------------------------------------------------
module lbs_ctrl #(
    parameter int INFLUENCE_COUNT = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  lbs_pkg::status_t status,
    output lbs_pkg::cmd_t    cmd
);

    localparam int USED = (INFLUENCE_COUNT < lbs_pkg::FIELD_INFLUENCES) ?
                          INFLUENCE_COUNT : lbs_pkg::FIELD_INFLUENCES;

    lbs_pkg::state_t state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [2:0] infl_reg, infl_next;
    logic       accept;

    assign accept = in_valid && in_ready;

    // State, step counter and influence index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lbs_pkg::ST_IDLE;
            cnt_reg   <= '0;
            infl_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            infl_reg  <= infl_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        infl_next  = infl_reg;
        unique case (state_reg)
            lbs_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = (status.is_vertex == lbs_pkg::KIND_VERTEX) ?
                                 lbs_pkg::ST_INIT : lbs_pkg::ST_WRITE;
            end
            lbs_pkg::ST_WRITE:
                state_next = lbs_pkg::ST_IDLE;
            lbs_pkg::ST_INIT:
            begin
                infl_next  = '0;
                state_next = lbs_pkg::ST_CHECK;
            end
            lbs_pkg::ST_CHECK:
            begin
                cnt_next = '0;
                if (infl_reg == 3'(USED))
                    state_next = lbs_pkg::ST_FINISH;
                else if (status.skip)
                    infl_next = infl_reg + 3'd1;
                else
                    state_next = lbs_pkg::ST_FETCH;
            end
            lbs_pkg::ST_FETCH:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(lbs_pkg::MATRIX_ELEMS - 1))
                    state_next = lbs_pkg::ST_DRAIN;
            end
            lbs_pkg::ST_DRAIN:
            begin
                if (!status.busy)
                    state_next = lbs_pkg::ST_DIVLOAD;
            end
            lbs_pkg::ST_DIVLOAD:
            begin
                cnt_next   = '0;
                state_next = lbs_pkg::ST_DIV;
            end
            lbs_pkg::ST_DIV:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(lbs_pkg::DIV_STEPS - 1))
                    state_next = lbs_pkg::ST_MUL;
            end
            lbs_pkg::ST_MUL:
                state_next = lbs_pkg::ST_ADD;
            lbs_pkg::ST_ADD:
            begin
                infl_next  = infl_reg + 3'd1;
                state_next = lbs_pkg::ST_CHECK;
            end
            lbs_pkg::ST_FINISH:
            begin
                if (status.out_free)
                    state_next = lbs_pkg::ST_IDLE;
            end
            default:
                state_next = lbs_pkg::ST_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd      = '0;
        cmd.elem = cnt_reg[3:0];
        cmd.infl = infl_reg;
        in_ready = 1'b0;
        unique case (state_reg)
            lbs_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = accept;
            end
            lbs_pkg::ST_WRITE:   cmd.write = 1'b1;
            lbs_pkg::ST_INIT:    cmd.init = 1'b1;
            lbs_pkg::ST_CHECK:   cmd.clear_sum = 1'b1;
            lbs_pkg::ST_FETCH:   cmd.rd_en = 1'b1;
            lbs_pkg::ST_DRAIN:   cmd.rd_en = 1'b0;
            lbs_pkg::ST_DIVLOAD: cmd.div_load = 1'b1;
            lbs_pkg::ST_DIV:     cmd.div_step = 1'b1;
            lbs_pkg::ST_MUL:     cmd.mul = 1'b1;
            lbs_pkg::ST_ADD:     cmd.add = 1'b1;
            lbs_pkg::ST_FINISH:  cmd.finish = status.out_free;
            default:             cmd = '0;
        endcase
    end

    // An accepted item always starts a write or a vertex pass
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == lbs_pkg::ST_WRITE || state_reg == lbs_pkg::ST_INIT))
        else $error("accepted item did not start work");

    // Influence index never passes the used count
    a_infl_range: assert property (@(posedge clk) disable iff (!rst_n)
        infl_reg <= 3'(USED))
        else $error("influence index out of range");

endmodule

@@ rtl/lbs_datapath.sv @@
// ----------------------------------------------------------------------------
// lbs_datapath: matrix store and arithmetic
// Skin matrix memory, multiply-accumulate of the homogeneous row, three
// restoring divider lanes, weighting, rounding and the output register.
// ----------------------------------------------------------------------------
module lbs_datapath #(
    parameter int JOINT_COUNT = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    lbs_in_if.sink           items,
    lbs_out_if.source        results,
    input  lbs_pkg::cmd_t    cmd,
    output lbs_pkg::status_t status
);

    localparam int DEPTH = JOINT_COUNT * 16;
    localparam int AW    = $clog2(DEPTH);

    // Captured item
    logic        kind_reg;
    logic [9:0]  addr_reg;
    logic [31:0] value_reg;
    logic signed [31:0] pos_reg [3];
    logic [23:0] ids_reg;
    logic [15:0] w_reg [4];

    // Matrix store and fetch pipeline
    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;
    logic        t1_valid_reg;
    logic [3:0]  t1_elem_reg;
    logic signed [63:0] prod_reg;
    logic        t2_valid_reg;
    logic [1:0]  t2_col_reg;
    logic signed [65:0] sum_reg [4];

    // Divider lanes
    logic [49:0] b_reg;
    logic        zero_reg;
    logic [50:0] rem_reg [3];
    logic [31:0] shq_reg [3];
    logic [31:0] quo_reg [3];
    logic        neg_reg [3];
    logic        hneg_reg [3];
    logic        ovf_reg [3];

    // Weighting and output
    logic signed [48:0] wprod_reg [3];
    logic signed [51:0] acc_reg [3];
    logic        fault_reg;
    logic        out_valid_reg;
    logic [31:0] out_reg [3];
    logic        out_fault_reg;

    logic [5:0]  joint_sel;
    logic [15:0] w_sel;
    logic signed [49:0] h [4];
    logic [49:0] habs [4];
    logic signed [31:0] pos_sel;
    logic [31:0] q [3];
    logic [2:0]  q_fault;
    logic [31:0] res [3];
    logic [2:0]  res_fault;

    assign joint_sel = ids_reg[6 * cmd.infl[1:0] +: 6];
    assign w_sel     = w_reg[cmd.infl[1:0]];

    assign status.is_vertex = items.kind;
    assign status.skip      = (w_sel == 16'd0) || (9'(joint_sel) >= 9'(JOINT_COUNT));
    assign status.busy      = t1_valid_reg || t2_valid_reg;
    assign status.out_free  = !out_valid_reg || results.ready;

    // Capture the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg   <= items.kind;
            addr_reg   <= items.load_address;
            value_reg  <= items.load_value;
            pos_reg[0] <= items.pos_x;
            pos_reg[1] <= items.pos_y;
            pos_reg[2] <= items.pos_z;
            ids_reg    <= items.joint_ids;
            w_reg[0]   <= items.weight_0;
            w_reg[1]   <= items.weight_1;
            w_reg[2]   <= items.weight_2;
            w_reg[3]   <= items.weight_3;
        end
    end

    // Store writes and registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.write && kind_reg == lbs_pkg::KIND_LOAD &&
            32'(addr_reg) < 32'(DEPTH))
            mem[AW'(addr_reg)] <= value_reg;
        if (cmd.rd_en)
            rd_data_reg <= mem[AW'({joint_sel, cmd.elem})];
    end

    // Fetch pipeline tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
        end
        else
        begin
            t1_valid_reg <= cmd.rd_en;
            t2_valid_reg <= t1_valid_reg;
        end
    end

    // Select the position coordinate for the fetched row
    always_comb
    begin
        case (t1_elem_reg[3:2])
            2'd0:    pos_sel = pos_reg[0];
            2'd1:    pos_sel = pos_reg[1];
            default: pos_sel = pos_reg[2];
        endcase
    end

    // Multiply row elements; the translation row enters shifted by 16
    always_ff @(posedge clk)
    begin
        t1_elem_reg <= cmd.elem;
        t2_col_reg  <= t1_elem_reg[1:0];
        if (t1_elem_reg[3:2] == 2'd3)
            prod_reg <= {{16{rd_data_reg[31]}}, rd_data_reg, 16'd0};
        else
            prod_reg <= pos_sel * $signed(rd_data_reg);
    end

    // Accumulate homogeneous sums
    always_ff @(posedge clk)
    begin
        if (cmd.clear_sum)
        begin
            for (int c = 0; c < 4; c++)
                sum_reg[c] <= '0;
        end
        else if (t2_valid_reg)
            sum_reg[t2_col_reg] <= sum_reg[t2_col_reg] + 66'(prod_reg);
    end

    // Floor by 2^16 and magnitudes
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            h[c]    = sum_reg[c][65:16];
            habs[c] = h[c][49] ? 50'(-h[c]) : 50'(h[c]);
        end
    end

    // Divider lanes: load, then one quotient bit per step
    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            b_reg    <= habs[3];
            zero_reg <= (h[3] == 50'sd0);
            for (int c = 0; c < 3; c++)
            begin
                rem_reg[c]  <= 51'(habs[c][49:16]);
                shq_reg[c]  <= {habs[c][15:0], 16'd0};
                quo_reg[c]  <= '0;
                hneg_reg[c] <= h[c][49];
                neg_reg[c]  <= h[c][49] ^ h[3][49];
                ovf_reg[c]  <= {16'd0, habs[c]} >= {habs[3], 16'd0};
            end
        end
        else if (cmd.div_step)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if ({rem_reg[c][49:0], shq_reg[c][31]} >= {1'b0, b_reg})
                begin
                    rem_reg[c] <= {rem_reg[c][49:0], shq_reg[c][31]} - {1'b0, b_reg};
                    quo_reg[c] <= {quo_reg[c][30:0], 1'b1};
                end
                else
                begin
                    rem_reg[c] <= {rem_reg[c][49:0], shq_reg[c][31]};
                    quo_reg[c] <= {quo_reg[c][30:0], 1'b0};
                end
                shq_reg[c] <= {shq_reg[c][30:0], 1'b0};
            end
        end
    end

    // Sign and saturate quotients
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            q_fault[c] = 1'b0;
            if (zero_reg)
            begin
                q[c]       = hneg_reg[c] ? lbs_pkg::Q_MIN : lbs_pkg::Q_MAX;
                q_fault[c] = 1'b1;
            end
            else if (ovf_reg[c])
            begin
                q[c]       = neg_reg[c] ? lbs_pkg::Q_MIN : lbs_pkg::Q_MAX;
                q_fault[c] = 1'b1;
            end
            else if (neg_reg[c])
            begin
                if (quo_reg[c] > lbs_pkg::Q_MIN)
                begin
                    q[c]       = lbs_pkg::Q_MIN;
                    q_fault[c] = 1'b1;
                end
                else
                    q[c] = -quo_reg[c];
            end
            else if (quo_reg[c][31])
            begin
                q[c]       = lbs_pkg::Q_MAX;
                q_fault[c] = 1'b1;
            end
            else
                q[c] = quo_reg[c];
        end
    end

    // Round half up to Q16.16 and saturate
    always_comb
    begin
        logic signed [51:0] rnd;
        for (int c = 0; c < 3; c++)
        begin
            rnd          = acc_reg[c] + 52'sd16384;
            res_fault[c] = 1'b0;
            if (rnd[51:46] == {6{rnd[51]}})
                res[c] = rnd[46:15];
            else
            begin
                res[c]       = rnd[51] ? lbs_pkg::Q_MIN : lbs_pkg::Q_MAX;
                res_fault[c] = 1'b1;
            end
        end
    end

    // Weight and accumulate
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            for (int c = 0; c < 3; c++)
                wprod_reg[c] <= $signed(q[c]) * $signed({1'b0, w_sel});
        end
        if (cmd.init)
        begin
            for (int c = 0; c < 3; c++)
                acc_reg[c] <= '0;
        end
        else if (cmd.add)
        begin
            for (int c = 0; c < 3; c++)
                acc_reg[c] <= acc_reg[c] + 52'(wprod_reg[c]);
        end
    end

    // Fault flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fault_reg <= 1'b0;
        else if (cmd.init)
            fault_reg <= 1'b0;
        else if (cmd.mul)
            fault_reg <= fault_reg || (|q_fault);
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            for (int c = 0; c < 3; c++)
                out_reg[c] <= res[c];
            out_fault_reg <= fault_reg || (|res_fault);
        end
    end

    assign results.valid = out_valid_reg;
    assign results.out_x = out_reg[0];
    assign results.out_y = out_reg[1];
    assign results.out_z = out_reg[2];
    assign results.fault = out_fault_reg;

    // Divider is loaded only after the fetch pipeline has drained
    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_load |-> !t1_valid_reg && !t2_valid_reg)
        else $error("divider loaded before matrix sums complete");

    // A result is loaded only into a free output register
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || results.ready))
        else $error("result overwrote a pending result");

    // A loaded result is presented in the next cycle
    a_out_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

@@ rtl/linear_blend_vertex_skinning.sv @@
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning: four-influence skinning in Q16.16
// A load item writes one word of the matrix store. A vertex runs each active
// influence through 16 matrix reads on the single store port and 32 steps
// of the divider lanes; a skipped influence is only checked. A new item is
// accepted only once the previous one has finished.
// Reset clears control and the output valid flag; the matrix store keeps
// its contents undefined until written.
// ----------------------------------------------------------------------------
module linear_blend_vertex_skinning #(
    parameter int JOINT_COUNT     = 64,
    parameter int INFLUENCE_COUNT = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    lbs_in_if.sink    items,
    lbs_out_if.source results
);

    lbs_pkg::cmd_t    cmd;
    lbs_pkg::status_t status;
    logic             in_ready;

    lbs_ctrl #(
        .INFLUENCE_COUNT (INFLUENCE_COUNT)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lbs_datapath #(
        .JOINT_COUNT (JOINT_COUNT)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results),
        .cmd     (cmd),
        .status  (status)
    );

    // Input handshake comes from the controller
    assign items.ready = in_ready;

endmodule
